>>> sv/dsf_pkg.sv
package dsf_pkg;

  typedef enum logic [2:0] {
    REG_ANCHOR_A_X        = 3'd0,
    REG_ANCHOR_A_Y        = 3'd1,
    REG_ANCHOR_B_X        = 3'd2,
    REG_ANCHOR_B_Y        = 3'd3,
    REG_SPRING_STIFFNESS  = 3'd4,
    REG_DAMPING_COEFF     = 3'd5,
    REG_REST_LENGTH       = 3'd6
  } cfg_reg_t;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] own_pos_x;
    logic signed [31:0] own_pos_y;
    logic signed [31:0] own_vel_x;
    logic signed [31:0] own_vel_y;
    logic               other_present;
    logic signed [31:0] other_pos_x;
    logic signed [31:0] other_pos_y;
    logic signed [31:0] other_vel_x;
    logic signed [31:0] other_vel_y;
  } item_t;

  typedef struct packed {
    logic signed [31:0] apply_at_x;
    logic signed [31:0] apply_at_y;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic               zero_length;
    logic               saturated;
  } result_t;

endpackage

>>> sv/dsf_delay.sv
module dsf_delay #(
  parameter int WD    = 8,
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          en,
  input  logic [WD-1:0] d,
  output logic [WD-1:0] q
);

  logic [WD-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  assign q = line[DEPTH-1];

endmodule

>>> sv/dsf_qmul.sv
module dsf_qmul #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] a,
  input  logic signed [W-1:0] b,
  output logic signed [W-1:0] p,
  output logic                clip
);

  localparam logic [2*W-1:0] LIM_POS = {{(W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [2*W-1:0] LIM_NEG = {{(W){1'b0}}, 1'b1, {(W-1){1'b0}}};

  logic [W-1:0]   ma;
  logic [W-1:0]   mb;
  logic [2*W-1:0] prod;
  logic           neg;
  logic [2*W-1:0] sh;
  logic [2*W-1:0] lim;

  assign ma = a[W-1] ? W'(-a) : W'(a);
  assign mb = b[W-1] ? W'(-b) : W'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= (2*W)'(ma) * (2*W)'(mb);
      neg  <= a[W-1] ^ b[W-1];
    end
  end

  assign sh  = prod >> F;
  assign lim = neg ? LIM_NEG : LIM_POS;

  always_ff @(posedge clk) begin
    if (en) begin
      if (sh > lim) begin
        clip <= 1'b1;
        p    <= neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
        clip <= 1'b0;
        p    <= neg ? -sh[W-1:0] : sh[W-1:0];
      end
    end
  end

endmodule

>>> sv/dsf_sqrt.sv
module dsf_sqrt #(
  parameter int N = 33
) (
  input  logic           clk,
  input  logic           en,
  input  logic [2*N-1:0] rad,
  output logic [N-1:0]   root
);

  logic [N:0]     rem_q  [N];
  logic [N-1:0]   root_q [N];
  logic [2*N-1:0] rest_q [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [N:0]     rin;
    logic [N-1:0]   tin;
    logic [2*N-1:0] sin;
    logic [N+1:0]   r2;
    logic [N+1:0]   trial;

    if (i == 0) begin : g_first
      assign rin = '0;
      assign tin = '0;
      assign sin = rad;
    end else begin : g_next
      assign rin = rem_q[i-1];
      assign tin = root_q[i-1];
      assign sin = rest_q[i-1];
    end

    assign r2    = {rin[N-1:0], sin[2*N-1 -: 2]};
    assign trial = {tin, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        if (r2 >= trial) begin
          rem_q[i]  <= (N+1)'(r2 - trial);
          root_q[i] <= {tin[N-2:0], 1'b1};
        end else begin
          rem_q[i]  <= r2[N:0];
          root_q[i] <= {tin[N-2:0], 1'b0};
        end
        rest_q[i] <= {sin[2*N-3:0], 2'b00};
      end
    end
  end

  assign root = root_q[N-1];

endmodule

>>> sv/dsf_div.sv
module dsf_div #(
  parameter int DW = 32,
  parameter int NW = 48,
  parameter int Q  = 18
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [Q-1:0]  quo
);

  logic [DW-1:0] rem_q [Q];
  logic [Q-1:0]  lo_q  [Q];
  logic [Q-1:0]  quo_q [Q];
  logic [DW-1:0] den_q [Q];

  for (genvar i = 0; i < Q; i++) begin : g_stage
    logic [DW-1:0] rin;
    logic [Q-1:0]  lin;
    logic [Q-1:0]  qin;
    logic [DW-1:0] din;
    logic [DW:0]   r2;
    logic          ge;

    if (i == 0) begin : g_first
      assign rin = DW'(num[NW-1:Q]);
      assign lin = num[Q-1:0];
      assign qin = '0;
      assign din = den;
    end else begin : g_next
      assign rin = rem_q[i-1];
      assign lin = lo_q[i-1];
      assign qin = quo_q[i-1];
      assign din = den_q[i-1];
    end

    assign r2 = {rin, lin[Q-1]};
    assign ge = r2 >= {1'b0, din};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i] <= ge ? DW'(r2 - {1'b0, din}) : r2[DW-1:0];
        lo_q[i]  <= lin << 1;
        quo_q[i] <= {qin[Q-2:0], ge};
        den_q[i] <= din;
      end
    end
  end

  assign quo = quo_q[Q-1];

endmodule

>>> sv/damped_spring_force.sv
// Damped 2D spring force in signed fixed point (WORD_WIDTH bits, FRAC_BITS fraction
// bits). One word is accepted per clock while the output is not stalled, and results
// come out in order; the square root resolves one root bit per stage and each
// divider one quotient bit per stage, and those two chains set the depth. A stall
// at the output halts the whole pipeline. Configuration writes are taken at any
// time but must only be made while no word is in flight.
module damped_spring_force #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_ready,
  input  dsf_pkg::item_t                       item,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output dsf_pkg::result_t                     result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dsf_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [dsf_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int W   = WORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int XW  = ((W > 32) ? W : 32) + 2;
  localparam int N   = W + 1;
  localparam int Q   = F + 2;
  localparam int CW  = ((Q > W) ? Q : W) + 1;
  localparam int LAT = W + F + 18;

  typedef logic signed [W-1:0] word_t;
  typedef struct packed { logic clip; word_t v; } sres_t;
  typedef struct packed { logic clip; logic signed [31:0] v; } o32_t;

  localparam logic signed [XW-1:0] XMAX = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [XW-1:0] XMIN = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [XW-1:0] OMAX = {{(XW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [XW-1:0] OMIN = {{(XW-31){1'b1}}, {31{1'b0}}};
  localparam logic [CW-1:0] ULIM_POS = {{(CW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [CW-1:0] ULIM_NEG = {{(CW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};

  function automatic sres_t sat_x(input logic signed [XW-1:0] x);
    sres_t r;
    if (x > XMAX) begin
      r.clip = 1'b1;
      r.v    = XMAX[W-1:0];
    end else if (x < XMIN) begin
      r.clip = 1'b1;
      r.v    = XMIN[W-1:0];
    end else begin
      r.clip = 1'b0;
      r.v    = x[W-1:0];
    end
    return r;
  endfunction

  function automatic sres_t sat_in(input logic signed [31:0] x);
    return sat_x(XW'(x));
  endfunction

  function automatic sres_t sadd(input word_t a, input word_t b);
    return sat_x(XW'(a) + XW'(b));
  endfunction

  function automatic sres_t ssub(input word_t a, input word_t b);
    return sat_x(XW'(a) - XW'(b));
  endfunction

  function automatic sres_t unit_of(input logic [Q-1:0] q, input logic neg);
    sres_t         r;
    logic [CW-1:0] qw;
    qw = CW'(q);
    if (qw > (neg ? ULIM_NEG : ULIM_POS)) begin
      r.clip = 1'b1;
      r.v    = neg ? XMIN[W-1:0] : XMAX[W-1:0];
    end else begin
      r.clip = 1'b0;
      r.v    = neg ? -qw[W-1:0] : qw[W-1:0];
    end
    return r;
  endfunction

  function automatic o32_t out32(input word_t f);
    o32_t                  r;
    logic signed [XW-1:0] e;
    e = XW'(f);
    if (e > OMAX) begin
      r.clip = 1'b1;
      r.v    = OMAX[31:0];
    end else if (e < OMIN) begin
      r.clip = 1'b1;
      r.v    = OMIN[31:0];
    end else begin
      r.clip = 1'b0;
      r.v    = e[31:0];
    end
    return r;
  endfunction

  // Configuration registers.
  logic signed [31:0] anchor_a_x, anchor_a_y, anchor_b_x, anchor_b_y;
  logic [30:0]        spring_stiffness, damping_coefficient, rest_length;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      anchor_a_x          <= '0;
      anchor_a_y          <= '0;
      anchor_b_x          <= '0;
      anchor_b_y          <= '0;
      spring_stiffness    <= '0;
      damping_coefficient <= '0;
      rest_length         <= '0;
    end else if (cfg_valid) begin
      case (dsf_pkg::cfg_reg_t'(cfg_index))
        dsf_pkg::REG_ANCHOR_A_X:       anchor_a_x          <= cfg_data;
        dsf_pkg::REG_ANCHOR_A_Y:       anchor_a_y          <= cfg_data;
        dsf_pkg::REG_ANCHOR_B_X:       anchor_b_x          <= cfg_data;
        dsf_pkg::REG_ANCHOR_B_Y:       anchor_b_y          <= cfg_data;
        dsf_pkg::REG_SPRING_STIFFNESS: spring_stiffness    <= cfg_data[30:0];
        dsf_pkg::REG_DAMPING_COEFF:    damping_coefficient <= cfg_data[30:0];
        dsf_pkg::REG_REST_LENGTH:      rest_length         <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  sres_t k_r, c_r, rest_r;
  assign k_r    = sat_x(XW'({1'b0, spring_stiffness}));
  assign c_r    = sat_x(XW'({1'b0, damping_coefficient}));
  assign rest_r = sat_x(XW'({1'b0, rest_length}));

  // Pipeline control.
  logic           en;
  logic [LAT-1:0] vld;

  assign result_valid = vld[LAT-1];
  assign en           = !result_valid || result_ready;
  assign item_ready   = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], item_valid};
    end
  end

  // Stage A: end points and relative velocity.
  logic signed [31:0] own_ax, own_ay, oth_ax, oth_ay;
  sres_t s_ox, s_oy, s_oax, s_oay, s_tax, s_tay, s_thx, s_thy;
  sres_t s_ex, s_ey, s_px, s_py, s_vx, s_vy, s_wx, s_wy, s_rx, s_ry;
  word_t a_ex, a_ey, a_px, a_py, a_vx, a_vy;
  logic  a_pre, a_post, a_mode;

  assign own_ax = item.mode ? anchor_b_x : anchor_a_x;
  assign own_ay = item.mode ? anchor_b_y : anchor_a_y;
  assign oth_ax = item.mode ? anchor_a_x : anchor_b_x;
  assign oth_ay = item.mode ? anchor_a_y : anchor_b_y;

  assign s_ox  = sat_in(item.own_pos_x);
  assign s_oy  = sat_in(item.own_pos_y);
  assign s_oax = sat_in(own_ax);
  assign s_oay = sat_in(own_ay);
  assign s_tax = sat_in(oth_ax);
  assign s_tay = sat_in(oth_ay);
  assign s_thx = sat_in(item.other_pos_x);
  assign s_thy = sat_in(item.other_pos_y);
  assign s_ex  = sadd(s_ox.v, s_oax.v);
  assign s_ey  = sadd(s_oy.v, s_oay.v);
  assign s_px  = sadd(s_thx.v, s_tax.v);
  assign s_py  = sadd(s_thy.v, s_tay.v);
  assign s_vx  = sat_in(item.own_vel_x);
  assign s_vy  = sat_in(item.own_vel_y);
  assign s_wx  = sat_in(item.other_vel_x);
  assign s_wy  = sat_in(item.other_vel_y);
  assign s_rx  = ssub(s_vx.v, s_wx.v);
  assign s_ry  = ssub(s_vy.v, s_wy.v);

  always_ff @(posedge clk) begin
    if (en) begin
      a_ex   <= s_ex.v;
      a_ey   <= s_ey.v;
      a_px   <= item.other_present ? s_px.v : s_tax.v;
      a_py   <= item.other_present ? s_py.v : s_tay.v;
      a_vx   <= item.other_present ? s_rx.v : s_vx.v;
      a_vy   <= item.other_present ? s_ry.v : s_vy.v;
      a_mode <= item.mode;
      a_pre  <= s_ox.clip | s_oy.clip | s_oax.clip | s_oay.clip | s_tax.clip | s_tay.clip
              | s_ex.clip | s_ey.clip
              | (item.other_present & (s_thx.clip | s_thy.clip | s_px.clip | s_py.clip));
      a_post <= s_vx.clip | s_vy.clip
              | (item.other_present & (s_wx.clip | s_wy.clip | s_rx.clip | s_ry.clip));
    end
  end

  // Stage B: separation as sign and magnitude.
  sres_t s_dx, s_dy;
  logic [W-1:0] b_mx, b_my;
  logic  b_nx, b_ny, b_pre, b_post, b_mode;
  word_t b_vx, b_vy;

  assign s_dx = ssub(a_ex, a_px);
  assign s_dy = ssub(a_ey, a_py);

  always_ff @(posedge clk) begin
    if (en) begin
      b_mx   <= s_dx.v[W-1] ? W'(-s_dx.v) : W'(s_dx.v);
      b_my   <= s_dy.v[W-1] ? W'(-s_dy.v) : W'(s_dy.v);
      b_nx   <= s_dx.v[W-1];
      b_ny   <= s_dy.v[W-1];
      b_vx   <= a_vx;
      b_vy   <= a_vy;
      b_pre  <= a_pre | s_dx.clip | s_dy.clip;
      b_post <= a_post;
      b_mode <= a_mode;
    end
  end

  // Stages C and D: squared length.
  typedef struct packed {
    logic [W-1:0] mx;
    logic [W-1:0] my;
    logic         nx;
    logic         ny;
    word_t        vx;
    word_t        vy;
    logic         pre;
    logic         post;
    logic         mode;
  } sb1_t;

  logic [2*W-1:0] c_sx, c_sy;
  logic [2*W:0]   d_s;
  sb1_t           c_sb, d_sb, sq_sb;

  always_ff @(posedge clk) begin
    if (en) begin
      c_sx <= (2*W)'(b_mx) * (2*W)'(b_mx);
      c_sy <= (2*W)'(b_my) * (2*W)'(b_my);
      c_sb <= '{mx: b_mx, my: b_my, nx: b_nx, ny: b_ny, vx: b_vx, vy: b_vy,
                pre: b_pre, post: b_post, mode: b_mode};
      d_s  <= (2*W+1)'(c_sx) + (2*W+1)'(c_sy);
      d_sb <= c_sb;
    end
  end

  logic [N-1:0] root;

  dsf_sqrt #(.N(N)) u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  ({1'b0, d_s}),
    .root (root)
  );

  dsf_delay #(.WD($bits(sb1_t)), .DEPTH(N)) u_dly_sqrt (
    .clk (clk),
    .en  (en),
    .d   (d_sb),
    .q   (sq_sb)
  );

  // Stage E: clamp length, spring extension.
  typedef struct packed {
    logic  nx;
    logic  ny;
    word_t vx;
    word_t vy;
    word_t diff;
    logic  zero;
    logic  pre;
    logic  post;
    logic  mode;
  } sb2_t;

  logic         lclip;
  word_t        lenc;
  sres_t        s_diff;
  logic [W-1:0] e_len;
  logic [W+F-1:0] e_numx, e_numy;
  sb2_t         e_sb, dv_sb;

  assign lclip  = root[W] | root[W-1];
  assign lenc   = lclip ? XMAX[W-1:0] : root[W-1:0];
  assign s_diff = ssub(lenc, rest_r.v);

  always_ff @(posedge clk) begin
    if (en) begin
      e_len  <= lenc;
      e_numx <= {sq_sb.mx, {F{1'b0}}};
      e_numy <= {sq_sb.my, {F{1'b0}}};
      e_sb   <= '{nx: sq_sb.nx, ny: sq_sb.ny, vx: sq_sb.vx, vy: sq_sb.vy,
                  diff: s_diff.v, zero: (root == '0), pre: sq_sb.pre,
                  post: sq_sb.post | lclip | rest_r.clip | s_diff.clip
                        | k_r.clip | c_r.clip,
                  mode: sq_sb.mode};
    end
  end

  logic [Q-1:0] qx, qy;

  dsf_div #(.DW(W), .NW(W+F), .Q(Q)) u_div_x (
    .clk (clk),
    .en  (en),
    .num (e_numx),
    .den (e_len),
    .quo (qx)
  );

  dsf_div #(.DW(W), .NW(W+F), .Q(Q)) u_div_y (
    .clk (clk),
    .en  (en),
    .num (e_numy),
    .den (e_len),
    .quo (qy)
  );

  dsf_delay #(.WD($bits(sb2_t)), .DEPTH(Q)) u_dly_div (
    .clk (clk),
    .en  (en),
    .d   (e_sb),
    .q   (dv_sb)
  );

  // Stage F: unit direction.
  typedef struct packed {
    word_t ux;
    word_t uy;
    logic  zero;
    logic  pre;
    logic  post;
    logic  mode;
  } sb3_t;

  sres_t s_ux, s_uy;
  word_t f_vx, f_vy, f_diff;
  sb3_t  f_sb, g_sb;

  assign s_ux = unit_of(qx, dv_sb.nx);
  assign s_uy = unit_of(qy, dv_sb.ny);

  always_ff @(posedge clk) begin
    if (en) begin
      f_vx   <= dv_sb.vx;
      f_vy   <= dv_sb.vy;
      f_diff <= dv_sb.diff;
      f_sb   <= '{ux: s_ux.v, uy: s_uy.v, zero: dv_sb.zero, pre: dv_sb.pre,
                  post: dv_sb.post | s_ux.clip | s_uy.clip, mode: dv_sb.mode};
    end
  end

  word_t pa, pb, pk;
  logic  ca, cb, ck;

  dsf_qmul #(.W(W), .F(F)) u_mul_vx (
    .clk (clk), .en (en), .a (f_vx), .b (f_sb.ux), .p (pa), .clip (ca)
  );

  dsf_qmul #(.W(W), .F(F)) u_mul_vy (
    .clk (clk), .en (en), .a (f_vy), .b (f_sb.uy), .p (pb), .clip (cb)
  );

  dsf_qmul #(.W(W), .F(F)) u_mul_k (
    .clk (clk), .en (en), .a (k_r.v), .b (f_diff), .p (pk), .clip (ck)
  );

  dsf_delay #(.WD($bits(sb3_t)), .DEPTH(2)) u_dly_g (
    .clk (clk),
    .en  (en),
    .d   (f_sb),
    .q   (g_sb)
  );

  // Stage H: velocity along the axis and spring term.
  typedef struct packed {
    word_t ux;
    word_t uy;
    word_t t;
    logic  zero;
    logic  pre;
    logic  post;
    logic  mode;
  } sb4_t;

  sres_t s_vdir, s_t;
  word_t h_vdir;
  sb4_t  h_sb, i_sb;

  assign s_vdir = sadd(pa, pb);
  assign s_t    = ssub('0, pk);

  always_ff @(posedge clk) begin
    if (en) begin
      h_vdir <= s_vdir.v;
      h_sb   <= '{ux: g_sb.ux, uy: g_sb.uy, t: s_t.v, zero: g_sb.zero, pre: g_sb.pre,
                  post: g_sb.post | ca | cb | ck | s_vdir.clip | s_t.clip,
                  mode: g_sb.mode};
    end
  end

  word_t pc;
  logic  cc;

  dsf_qmul #(.W(W), .F(F)) u_mul_c (
    .clk (clk), .en (en), .a (c_r.v), .b (h_vdir), .p (pc), .clip (cc)
  );

  dsf_delay #(.WD($bits(sb4_t)), .DEPTH(2)) u_dly_i (
    .clk (clk),
    .en  (en),
    .d   (h_sb),
    .q   (i_sb)
  );

  // Stage J: force magnitude.
  typedef struct packed {
    logic zero;
    logic pre;
    logic post;
    logic mode;
  } sb5_t;

  sres_t s_mag;
  word_t j_mag, j_ux, j_uy;
  sb5_t  j_sb, k_sb;

  assign s_mag = ssub(i_sb.t, pc);

  always_ff @(posedge clk) begin
    if (en) begin
      j_mag <= s_mag.v;
      j_ux  <= i_sb.ux;
      j_uy  <= i_sb.uy;
      j_sb  <= '{zero: i_sb.zero, pre: i_sb.pre, post: i_sb.post | cc | s_mag.clip,
                 mode: i_sb.mode};
    end
  end

  word_t pfx, pfy;
  logic  cfx, cfy;

  dsf_qmul #(.W(W), .F(F)) u_mul_fx (
    .clk (clk), .en (en), .a (j_ux), .b (j_mag), .p (pfx), .clip (cfx)
  );

  dsf_qmul #(.W(W), .F(F)) u_mul_fy (
    .clk (clk), .en (en), .a (j_uy), .b (j_mag), .p (pfy), .clip (cfy)
  );

  dsf_delay #(.WD($bits(sb5_t)), .DEPTH(2)) u_dly_k (
    .clk (clk),
    .en  (en),
    .d   (j_sb),
    .q   (k_sb)
  );

  // Output register.
  o32_t o_fx, o_fy;

  assign o_fx = out32(pfx);
  assign o_fy = out32(pfy);

  always_ff @(posedge clk) begin
    if (en) begin
      result.apply_at_x  <= k_sb.mode ? anchor_b_x : anchor_a_x;
      result.apply_at_y  <= k_sb.mode ? anchor_b_y : anchor_a_y;
      result.force_x     <= k_sb.zero ? '0 : o_fx.v;
      result.force_y     <= k_sb.zero ? '0 : o_fy.v;
      result.zero_length <= k_sb.zero;
      result.saturated   <= k_sb.pre
                          | (!k_sb.zero & (k_sb.post | cfx | cfy | o_fx.clip | o_fy.clip));
    end
  end

endmodule

>>> sv/dsf_chk.sv
module dsf_chk (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_ready,
  input logic             result_valid,
  input logic             result_ready,
  input dsf_pkg::result_t result,
  input logic             cfg_ready
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> item_ready)
    else $error("input stalled with an empty output");

  a_zero_force: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.zero_length |-> result.force_x == 0 && result.force_y == 0)
    else $error("nonzero force on a zero length spring");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    item_valid |-> cfg_ready)
    else $error("configuration port not ready");

endmodule

bind damped_spring_force dsf_chk u_dsf_chk (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result),
  .cfg_ready    (cfg_ready)
);
